[design/gsa_pkg.sv]
package gsa_pkg;

    localparam int CAPACITY     = 256;
    localparam int GEN_BITS     = 16;
    localparam int PAYLOAD_BITS = 32;
    localparam int IDX_W        = $clog2(CAPACITY);
    localparam int CNT_W        = $clog2(CAPACITY + 1);

    localparam logic [1:0] ACT_ADD     = 2'd0;
    localparam logic [1:0] ACT_RELEASE = 2'd1;
    localparam logic [1:0] ACT_CLEAR   = 2'd2;

    localparam logic [1:0] STATUS_OK    = 2'd0;
    localparam logic [1:0] STATUS_NULL  = 2'd1;
    localparam logic [1:0] STATUS_FULL  = 2'd2;
    localparam logic [1:0] STATUS_STALE = 2'd3;

    typedef struct packed {
        logic [PAYLOAD_BITS-1:0] payload;
        logic [GEN_BITS-1:0]     generation;
        logic                    live;
    } slot_entry_t;

    typedef struct packed {
        logic [IDX_W-1:0]    index;
        logic [GEN_BITS-1:0] generation;
    } stack_entry_t;

endpackage

[design/gsa_ram.sv]
module gsa_ram
    import gsa_pkg::*;
#(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

[design/generational_slot_allocator_top.sv]
// Channel   Direction  Handshake                 Fields
// command   in         start && !busy            action, payload, handle_index,
//                                                handle_generation, handle_valid
// result    out        done, one cycle           status, out_index, out_generation,
//                                                out_valid, removed_payload, removed_valid
//
// Every transaction reads the slot and free stack memories at the accepting edge and writes
// them back at the edge on which the result is registered. The done strobe is registered
// with the result, and the next transaction may start while it is high.
// Reset empties the pool; the memories need no clearing pass.
// The receiver cannot stall the block.
module generational_slot_allocator_top
    import gsa_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [1:0]  action,
    input  logic [31:0] payload,
    input  logic [7:0]  handle_index,
    input  logic [15:0] handle_generation,
    input  logic        handle_valid,
    output logic        done,
    output logic [1:0]  status,
    output logic [7:0]  out_index,
    output logic [15:0] out_generation,
    output logic        out_valid,
    output logic [31:0] removed_payload,
    output logic        removed_valid
);

    typedef enum logic {
        ST_IDLE,
        ST_EXEC
    } state_t;

    state_t                  state_reg;
    logic [1:0]              action_reg;
    logic [PAYLOAD_BITS-1:0] payload_reg;
    logic [IDX_W-1:0]        hidx_reg;
    logic [GEN_BITS-1:0]     hgen_reg;
    logic                    hvalid_reg;
    logic [CNT_W-1:0]        free_count_reg, free_count_next;
    logic [CNT_W-1:0]        slots_used_reg, slots_used_next;

    logic                    done_reg;
    logic [1:0]              status_reg, status_next;
    logic [7:0]              out_index_reg, out_index_next;
    logic [15:0]             out_generation_reg, out_generation_next;
    logic                    out_valid_reg, out_valid_next;
    logic [31:0]             removed_payload_reg, removed_payload_next;
    logic                    removed_valid_reg, removed_valid_next;

    slot_entry_t             slot_rdata, slot_wdata;
    stack_entry_t            stack_rdata, stack_wdata;
    logic                    slot_we, stack_we;
    logic [IDX_W-1:0]        slot_waddr, stack_waddr, stack_raddr;
    logic                    accept;
    logic [CNT_W-1:0]        stack_top;
    logic [GEN_BITS-1:0]     bumped_gen;

    assign accept      = start && (state_reg == ST_IDLE);
    assign busy        = (state_reg == ST_EXEC);
    assign stack_top   = free_count_reg - CNT_W'(1);
    assign stack_raddr = stack_top[IDX_W-1:0];
    assign bumped_gen  = slot_rdata.generation + GEN_BITS'(1);

    gsa_ram #(
        .WIDTH ($bits(slot_entry_t)),
        .DEPTH (CAPACITY)
    ) u_slot_ram (
        .clk   (clk),
        .we    (slot_we),
        .waddr (slot_waddr),
        .wdata (slot_wdata),
        .raddr (handle_index[IDX_W-1:0]),
        .rdata (slot_rdata)
    );

    gsa_ram #(
        .WIDTH ($bits(stack_entry_t)),
        .DEPTH (CAPACITY)
    ) u_stack_ram (
        .clk   (clk),
        .we    (stack_we),
        .waddr (stack_waddr),
        .wdata (stack_wdata),
        .raddr (stack_raddr),
        .rdata (stack_rdata)
    );

    always_comb
    begin
        free_count_next      = free_count_reg;
        slots_used_next      = slots_used_reg;
        status_next          = STATUS_OK;
        out_index_next       = '0;
        out_generation_next  = '0;
        out_valid_next       = 1'b0;
        removed_payload_next = '0;
        removed_valid_next   = 1'b0;
        slot_we              = 1'b0;
        slot_waddr           = hidx_reg;
        slot_wdata           = '0;
        stack_we             = 1'b0;
        stack_waddr          = free_count_reg[IDX_W-1:0];
        stack_wdata          = '0;

        if (state_reg == ST_EXEC)
        begin
            unique case (action_reg)
                ACT_ADD:
                begin
                    priority if (payload_reg == '0)
                    begin
                        status_next = STATUS_NULL;
                    end
                    else if (free_count_reg != '0)
                    begin
                        free_count_next     = stack_top;
                        slot_we             = 1'b1;
                        slot_waddr          = stack_rdata.index;
                        slot_wdata          = '{payload_reg, stack_rdata.generation, 1'b1};
                        out_index_next      = 8'(stack_rdata.index);
                        out_generation_next = 16'(stack_rdata.generation);
                        out_valid_next      = 1'b1;
                    end
                    else if (slots_used_reg < CNT_W'(CAPACITY))
                    begin
                        slots_used_next     = slots_used_reg + CNT_W'(1);
                        slot_we             = 1'b1;
                        slot_waddr          = slots_used_reg[IDX_W-1:0];
                        slot_wdata          = '{payload_reg, {GEN_BITS{1'b0}}, 1'b1};
                        out_index_next      = 8'(slots_used_reg[IDX_W-1:0]);
                        out_valid_next      = 1'b1;
                    end
                    else
                    begin
                        status_next = STATUS_FULL;
                    end
                end
                ACT_RELEASE:
                begin
                    priority if (!hvalid_reg)
                    begin
                        status_next = STATUS_NULL;
                    end
                    else if (CNT_W'(hidx_reg) >= slots_used_reg)
                    begin
                        status_next = STATUS_STALE;
                    end
                    else if (slot_rdata.generation != hgen_reg || !slot_rdata.live)
                    begin
                        status_next = STATUS_STALE;
                    end
                    else
                    begin
                        slot_we              = 1'b1;
                        slot_wdata           = '{{PAYLOAD_BITS{1'b0}}, bumped_gen, 1'b0};
                        removed_payload_next = 32'(slot_rdata.payload);
                        removed_valid_next   = 1'b1;
                        if (free_count_reg < CNT_W'(CAPACITY))
                        begin
                            stack_we        = 1'b1;
                            stack_wdata     = '{hidx_reg, bumped_gen};
                            free_count_next = free_count_reg + CNT_W'(1);
                        end
                    end
                end
                ACT_CLEAR:
                begin
                    free_count_next = '0;
                    slots_used_next = '0;
                end
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg           <= ST_IDLE;
            free_count_reg      <= '0;
            slots_used_reg      <= '0;
            done_reg            <= 1'b0;
            action_reg          <= '0;
            payload_reg         <= '0;
            hidx_reg            <= '0;
            hgen_reg            <= '0;
            hvalid_reg          <= 1'b0;
            status_reg          <= STATUS_OK;
            out_index_reg       <= '0;
            out_generation_reg  <= '0;
            out_valid_reg       <= 1'b0;
            removed_payload_reg <= '0;
            removed_valid_reg   <= 1'b0;
        end
        else
        begin
            unique case (state_reg)
                ST_IDLE:
                begin
                    done_reg <= 1'b0;
                    if (accept)
                    begin
                        state_reg   <= ST_EXEC;
                        action_reg  <= action;
                        payload_reg <= payload[PAYLOAD_BITS-1:0];
                        hidx_reg    <= handle_index[IDX_W-1:0];
                        hgen_reg    <= handle_generation[GEN_BITS-1:0];
                        hvalid_reg  <= handle_valid;
                    end
                end
                ST_EXEC:
                begin
                    state_reg           <= ST_IDLE;
                    done_reg            <= 1'b1;
                    free_count_reg      <= free_count_next;
                    slots_used_reg      <= slots_used_next;
                    status_reg          <= status_next;
                    out_index_reg       <= out_index_next;
                    out_generation_reg  <= out_generation_next;
                    out_valid_reg       <= out_valid_next;
                    removed_payload_reg <= removed_payload_next;
                    removed_valid_reg   <= removed_valid_next;
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign done            = done_reg;
    assign status          = status_reg;
    assign out_index       = out_index_reg;
    assign out_generation  = out_generation_reg;
    assign out_valid       = out_valid_reg;
    assign removed_payload = removed_payload_reg;
    assign removed_valid   = removed_valid_reg;

endmodule
